>>> hdl/wav_header_parser_core_macros.svh
// ----------------------------------------------------------------------------
// wav header parser assertion macros
// shared property templates for the port-level checker
// ----------------------------------------------------------------------------
`ifndef WAV_HEADER_PARSER_CORE_MACROS_SVH
`define WAV_HEADER_PARSER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define WHP_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wav header parser check failed");

// next-cycle implication, sampled on clk, off while in reset
`define WHP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wav header parser check failed");

`endif

>>> hdl/wav_hdr_pkg.sv
// ----------------------------------------------------------------------------
// wav header parser package
// tags, parse phases, beat kinds, error codes and output field layout
// ----------------------------------------------------------------------------
package wav_hdr_pkg;

	// little-endian tag words as assembled from the byte stream
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	// parse phases
	localparam logic [3:0] PH_WAIT       = 4'd0;
	localparam logic [3:0] PH_RIFF_TAG   = 4'd1;
	localparam logic [3:0] PH_RIFF_SIZE  = 4'd2;
	localparam logic [3:0] PH_WAVE_TAG   = 4'd3;
	localparam logic [3:0] PH_FMT_TAG    = 4'd4;
	localparam logic [3:0] PH_FMT_SIZE   = 4'd5;
	localparam logic [3:0] PH_FMT_BODY   = 4'd6;
	localparam logic [3:0] PH_FMT_EXTRA  = 4'd7;
	localparam logic [3:0] PH_CHUNK_TAG  = 4'd8;
	localparam logic [3:0] PH_CHUNK_SIZE = 4'd9;
	localparam logic [3:0] PH_CHUNK_SKIP = 4'd10;
	localparam logic [3:0] PH_DATA_SIZE  = 4'd11;
	localparam logic [3:0] PH_PCM        = 4'd12;

	// result beat kinds
	localparam logic [2:0] KIND_HEADER   = 3'd0;
	localparam logic [2:0] KIND_PCM      = 3'd1;
	localparam logic [2:0] KIND_PCM_LAST = 3'd2;
	localparam logic [2:0] KIND_IGNORED  = 3'd3;
	localparam logic [2:0] KIND_ERROR    = 3'd4;

	// error codes
	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_NOT_RIFF   = 3'd1;
	localparam logic [2:0] ERR_NOT_WAVE   = 3'd2;
	localparam logic [2:0] ERR_NO_FMT     = 3'd3;
	localparam logic [2:0] ERR_FMT_SIZE   = 3'd4;
	localparam logic [2:0] ERR_CHUNK_SIZE = 3'd5;
	localparam logic [2:0] ERR_ZERO_DATA  = 3'd6;
	localparam logic [2:0] ERR_TRUNCATED  = 3'd7;

	// result tdata width (156 field bits padded to whole bytes)
	localparam int unsigned RES_W = 160;

	// bit positions of the data size field inside result tdata
	localparam int unsigned DSIZE_LO = 123;
	localparam int unsigned DSIZE_HI = 153;

	typedef struct packed {
		logic [2:0]       kind;
		logic [RES_W-1:0] data;
	} result_t;

endpackage

>>> hdl/wav_header_parser_core.sv
// a result beat is registered from its byte beat, via the skid entry when the result register is stalled
// throughput: one byte beat per cycle while the skid entry is empty; per-byte work is a phase update and a tag compare
// output side has a result register plus one skid entry, so s_tready depends only on
// whether the skid entry is full and never on m_tready in the same cycle
// reset: arst_n clears the parser to waiting for file start and empties both entries
// ----------------------------------------------------------------------------
// wav header parser core
// byte-serial riff/wave header parser that captures fmt fields and passes pcm through
// ----------------------------------------------------------------------------
module wav_header_parser_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// byte beats in
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // file_byte[7:0]
	input  logic [0:0]                    s_tuser,   // file_start[0]
	input  logic                          s_tlast,   // file_end
	// result beats out
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// error_kind[2:0], pcm_byte[10:3], format_tag[26:11], channel_count[42:27],
	// rate_hz[74:43], bytes_per_sec[106:75], sample_bits[122:107],
	// data_size[153:123], sample_layout[155:154], zero pad[159:156]
	output logic [wav_hdr_pkg::RES_W-1:0] m_tdata,
	output logic [2:0]                    m_tuser    // item_kind[2:0]
);
	import wav_hdr_pkg::*;

	// parser state
	logic [3:0]  phase_q;
	logic [4:0]  pos_q;
	logic [31:0] word_q;
	logic [31:0] left_q;
	logic [15:0] fmt_tag_q;
	logic [15:0] chans_q;
	logic [31:0] rate_q;
	logic [31:0] brate_q;
	logic [15:0] bits_q;
	logic [30:0] dsize_q;
	logic [2:0]  err_q;

	// next state
	logic [3:0]  phase_d;
	logic [4:0]  pos_d;
	logic [31:0] word_d;
	logic [31:0] left_d;
	logic [15:0] fmt_tag_d;
	logic [15:0] chans_d;
	logic [31:0] rate_d;
	logic [31:0] brate_d;
	logic [15:0] bits_d;
	logic [30:0] dsize_d;
	logic [2:0]  err_d;

	logic [2:0]  kind_d;
	logic [2:0]  new_err;
	logic [7:0]  pcm_d;
	logic [1:0]  layout_d;

	// byte shifted into the assembly word, and the bumped byte count
	logic [31:0] word_base;
	logic [31:0] w_next;
	logic [4:0]  pos_base;
	logic [4:0]  pos_inc;

	logic        file_start;
	logic        file_end;
	logic        accept;
	logic        take;

	result_t     res_d;
	result_t     out_q;
	result_t     skid_q;
	logic        out_valid_q;
	logic        skid_valid_q;

	assign file_start = s_tuser[0];
	assign file_end   = s_tlast;
	assign accept     = s_tvalid && s_tready;
	assign take       = m_tvalid && m_tready;

	// a file start clears the assembly word and count before this byte lands
	assign word_base = file_start ? '0 : word_q;
	assign pos_base  = file_start ? '0 : pos_q;
	assign w_next    = {s_tdata, word_base[31:8]};
	assign pos_inc   = pos_base + 5'd1;

	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		word_d    = word_q;
		left_d    = left_q;
		fmt_tag_d = fmt_tag_q;
		chans_d   = chans_q;
		rate_d    = rate_q;
		brate_d   = brate_q;
		bits_d    = bits_q;
		dsize_d   = dsize_q;
		err_d     = err_q;
		kind_d    = KIND_IGNORED;
		new_err   = ERR_NONE;
		pcm_d     = '0;

		if (file_start) begin
			phase_d   = PH_RIFF_TAG;
			pos_d     = '0;
			word_d    = '0;
			left_d    = '0;
			fmt_tag_d = '0;
			chans_d   = '0;
			rate_d    = '0;
			brate_d   = '0;
			bits_d    = '0;
			dsize_d   = '0;
			err_d     = ERR_NONE;
		end

		case (phase_d)
			PH_WAIT: begin
				kind_d = KIND_IGNORED;
			end
			PH_FMT_BODY: begin
				// fixed 16-byte fmt body, fields picked off as they complete
				kind_d = KIND_HEADER;
				word_d = w_next;
				pos_d  = pos_inc;
				if (pos_inc == 5'd2) begin
					fmt_tag_d = w_next[31:16];
				end else if (pos_inc == 5'd4) begin
					chans_d = w_next[31:16];
				end else if (pos_inc == 5'd8) begin
					rate_d = w_next;
				end else if (pos_inc == 5'd12) begin
					brate_d = w_next;
				end else if (pos_inc == 5'd16) begin
					bits_d  = w_next[31:16];
					pos_d   = '0;
					phase_d = (left_d != '0) ? PH_FMT_EXTRA : PH_CHUNK_TAG;
				end
			end
			PH_FMT_EXTRA, PH_CHUNK_SKIP: begin
				kind_d = KIND_HEADER;
				left_d = left_d - 32'd1;
				if (left_d == '0) begin
					phase_d = PH_CHUNK_TAG;
				end
			end
			PH_PCM: begin
				kind_d = KIND_PCM;
				pcm_d  = s_tdata;
				left_d = left_d - 32'd1;
				if (left_d == '0) begin
					kind_d  = KIND_PCM_LAST;
					phase_d = PH_WAIT;
				end
			end
			default: begin
				// tag and size words, judged on their fourth byte
				kind_d = KIND_HEADER;
				word_d = w_next;
				pos_d  = pos_inc;
				if (pos_inc >= 5'd4) begin
					pos_d = '0;
					case (phase_d)
						PH_RIFF_TAG: begin
							if (w_next != TAG_RIFF) new_err = ERR_NOT_RIFF;
							else phase_d = PH_RIFF_SIZE;
						end
						PH_RIFF_SIZE: begin
							phase_d = PH_WAVE_TAG;
						end
						PH_WAVE_TAG: begin
							if (w_next != TAG_WAVE) new_err = ERR_NOT_WAVE;
							else phase_d = PH_FMT_TAG;
						end
						PH_FMT_TAG: begin
							if (w_next != TAG_FMT) new_err = ERR_NO_FMT;
							else phase_d = PH_FMT_SIZE;
						end
						PH_FMT_SIZE: begin
							if (w_next[31] || (w_next < 32'd16)) begin
								new_err = ERR_FMT_SIZE;
							end else begin
								// extra bytes past the body, plus pad on odd sizes
								left_d  = (w_next - 32'd16) + {31'd0, w_next[0]};
								phase_d = PH_FMT_BODY;
							end
						end
						PH_CHUNK_TAG: begin
							phase_d = (w_next == TAG_DATA) ? PH_DATA_SIZE : PH_CHUNK_SIZE;
						end
						PH_CHUNK_SIZE: begin
							if (w_next[31]) begin
								new_err = ERR_CHUNK_SIZE;
							end else begin
								left_d  = w_next + {31'd0, w_next[0]};
								phase_d = (left_d != '0) ? PH_CHUNK_SKIP : PH_CHUNK_TAG;
							end
						end
						PH_DATA_SIZE: begin
							if (w_next[31]) begin
								new_err = ERR_CHUNK_SIZE;
							end else if (w_next == '0) begin
								new_err = ERR_ZERO_DATA;
							end else begin
								dsize_d = w_next[30:0];
								left_d  = w_next;
								phase_d = PH_PCM;
							end
						end
						default: begin
							new_err = ERR_NONE;
						end
					endcase
				end
			end
		endcase

		// end of file mid-parse is truncation unless this byte already failed
		if ((new_err == ERR_NONE) && file_end && (phase_d != PH_WAIT)) begin
			new_err = ERR_TRUNCATED;
		end
		if (new_err != ERR_NONE) begin
			err_d   = new_err;
			kind_d  = KIND_ERROR;
			pcm_d   = '0;
			phase_d = PH_WAIT;
		end
		if (file_end) begin
			phase_d = PH_WAIT;
		end
	end

	// stereo when not exactly one channel, 16-bit layout when not exactly 8 bits
	assign layout_d = {(chans_d != 16'd1), (bits_d != 16'd8)};

	always_comb begin
		res_d.kind = kind_d;
		res_d.data = {4'd0, layout_d, dsize_d, bits_d, brate_d, rate_d, chans_d,
			fmt_tag_d, pcm_d, err_d};
	end

	// parser state moves only on an accepted byte beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_WAIT;
			pos_q     <= '0;
			word_q    <= '0;
			left_q    <= '0;
			fmt_tag_q <= '0;
			chans_q   <= '0;
			rate_q    <= '0;
			brate_q   <= '0;
			bits_q    <= '0;
			dsize_q   <= '0;
			err_q     <= ERR_NONE;
		end else if (accept) begin
			phase_q   <= phase_d;
			pos_q     <= pos_d;
			word_q    <= word_d;
			left_q    <= left_d;
			fmt_tag_q <= fmt_tag_d;
			chans_q   <= chans_d;
			rate_q    <= rate_d;
			brate_q   <= brate_d;
			bits_q    <= bits_d;
			dsize_q   <= dsize_d;
			err_q     <= err_d;
		end
	end

	// result register with one skid entry behind it
	assign s_tready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || take) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res_d;
			end
		end else if (accept) begin
			skid_q <= res_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.data;
	assign m_tuser  = out_q.kind;

endmodule

>>> hdl/wav_hdr_checker.sv
// ----------------------------------------------------------------------------
// wav header parser port checker
// watches the result side of the core over time
// ----------------------------------------------------------------------------
`include "wav_header_parser_core_macros.svh"

module wav_hdr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [wav_hdr_pkg::RES_W-1:0] m_tdata,
	input logic [2:0]                    m_tuser
);
	import wav_hdr_pkg::*;

	logic [2:0] beat_err;
	logic [7:0] beat_pcm;
	logic       beat_sample;
	logic       beat_live;

	assign beat_err    = m_tdata[2:0];
	assign beat_pcm    = m_tdata[10:3];
	assign beat_sample = (m_tuser == KIND_PCM) || (m_tuser == KIND_PCM_LAST);
	// header or sample beat of an active parse
	assign beat_live   = beat_sample || (m_tuser == KIND_HEADER);

	// a stalled result beat holds
	`WHP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// input is only held off while a result is pending
	`WHP_ASSERT_IMPL(a_ready_backpressure, !s_tready, m_tvalid)

	// error beats carry a code and no sample byte
	`WHP_ASSERT_IMPL(a_error_beat, m_tvalid && (m_tuser == KIND_ERROR), (beat_err != ERR_NONE) && (beat_pcm == 8'd0))

	// an active parse has no latched error
	`WHP_ASSERT_IMPL(a_active_clean, m_tvalid && beat_live, beat_err == ERR_NONE)

	// sample bytes only flow once a non-zero data size is known
	`WHP_ASSERT_IMPL(a_pcm_has_size, m_tvalid && beat_sample, m_tdata[DSIZE_HI:DSIZE_LO] != '0)

endmodule

bind wav_header_parser_core wav_hdr_checker u_wav_hdr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
